// ===== hw/rtl/robs_pkg.sv =====
// Shared types and constants for the reading-order box sorter.
// No dependencies.
`default_nettype none
package robs_pkg;
    localparam int FIELD_BITS = 16;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic sort_read;
        logic sort_step;
        logic pass_skip;
        logic sweep_init;
        logic pos_read;
        logic box_read;
        logic mark_step;
        logic emit_step;
        logic clear;
    } robs_cmd_t;

    typedef struct packed {
        logic sort_done;
        logic pair_ok;
        logic sweep_done;
        logic out_busy;
    } robs_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/robs_datapath.sv =====
// Datapath: box store, sort list, compare/swap unit, line marker and output register.
// Depends on robs_pkg.
`default_nettype none
module robs_datapath #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire robs_pkg::robs_cmd_t                cmd,
    output robs_pkg::robs_sts_t                     sts,
    input  wire logic [robs_pkg::FIELD_BITS-1:0]    box_left,
    input  wire logic [robs_pkg::FIELD_BITS-1:0]    box_top,
    input  wire logic [robs_pkg::FIELD_BITS-1:0]    box_width,
    input  wire logic [robs_pkg::FIELD_BITS-1:0]    box_height,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [robs_pkg::FIELD_BITS-1:0]         out_left,
    output logic [robs_pkg::FIELD_BITS-1:0]         out_top,
    output logic [robs_pkg::FIELD_BITS-1:0]         out_width,
    output logic [robs_pkg::FIELD_BITS-1:0]         out_height,
    output logic                                    out_final,
    output logic                                    overflowed
);
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int CB = COORD_BITS;
    localparam int FB = robs_pkg::FIELD_BITS;
    localparam int BW = 4 * CB;          // left, top, width, height
    localparam int KW = CW + CB;         // sort key: line number, coordinate
    localparam int EW = KW + IW;         // sort entry: key, box index

    // Box store and sort list, both with registered reads. The sort list
    // starts as {0, top, index}; after line marking it holds
    // {line, left, index}, so one stable sort gives reading order.
    logic [BW-1:0] box_mem [MAX_BOXES];
    logic [EW-1:0] srt_mem [MAX_BOXES];

    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic [CW-1:0] pos_reg;       // compared pair is pos, pos+1
    logic [CW-1:0] pass_reg;
    logic [CW-1:0] swp_reg;       // mark / emit position
    logic [CW-1:0] line_reg;
    logic [CB:0]   prev_bot_reg;
    logic [EW-1:0] rd_a_reg;
    logic [EW-1:0] rd_b_reg;
    logic [BW-1:0] box_rd_reg;

    logic          out_valid_reg;
    logic [FB-1:0] out_left_reg;
    logic [FB-1:0] out_top_reg;
    logic [FB-1:0] out_width_reg;
    logic [FB-1:0] out_height_reg;
    logic          out_final_reg;
    logic          ovf_out_reg;

    logic [IW-1:0] pos_a, pos_b, swp_a, rd_addr;
    logic          full, swap, pair_ok, last_pair, brk;
    logic [CB-1:0] bx_left, bx_top, bx_wid, bx_hgt;
    logic [CW-1:0] line_new;

    always_comb
    begin
        pos_a     = pos_reg[IW-1:0];
        pos_b     = pos_a + IW'(1);
        swp_a     = swp_reg[IW-1:0];
        rd_addr   = cmd.sort_read ? pos_a : swp_a;
        full      = (cnt_reg >= CW'(MAX_BOXES));
        // strict compare keeps equal keys in place: stable
        swap      = (rd_a_reg[EW-1:IW] > rd_b_reg[EW-1:IW]);
        pair_ok   = ({1'b0, pos_reg} + (CW+1)'(1)) < {1'b0, cnt_reg};
        last_pair = ({1'b0, pos_reg} + (CW+1)'(3)) >= {1'b0, cnt_reg};
        bx_left   = box_rd_reg[4*CB-1 -: CB];
        bx_top    = box_rd_reg[3*CB-1 -: CB];
        bx_wid    = box_rd_reg[2*CB-1 -: CB];
        bx_hgt    = box_rd_reg[CB-1:0];
        // new line when the top lies strictly below the previous bottom
        brk       = (swp_reg != '0) && ({1'b0, bx_top} > prev_bot_reg);
        line_new  = line_reg + CW'(brk);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            box_mem[cnt_reg[IW-1:0]] <= {box_left[CB-1:0], box_top[CB-1:0],
                                         box_width[CB-1:0], box_height[CB-1:0]};
            srt_mem[cnt_reg[IW-1:0]] <= {{CW{1'b0}}, box_top[CB-1:0], cnt_reg[IW-1:0]};
        end
        if (cmd.sort_step && swap)
        begin
            srt_mem[pos_a] <= rd_b_reg;
            srt_mem[pos_b] <= rd_a_reg;
        end
        if (cmd.mark_step)
            srt_mem[swp_a] <= {line_new, bx_left, rd_a_reg[IW-1:0]};
        if (cmd.sort_read || cmd.pos_read)
            rd_a_reg <= srt_mem[rd_addr];
        if (cmd.sort_read)
            rd_b_reg <= srt_mem[pos_b];
        if (cmd.box_read)
            box_rd_reg <= box_mem[rd_a_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            pos_reg        <= '0;
            pass_reg       <= '0;
            swp_reg        <= '0;
            line_reg       <= '0;
            prev_bot_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_left_reg   <= '0;
            out_top_reg    <= '0;
            out_width_reg  <= '0;
            out_height_reg <= '0;
            out_final_reg  <= 1'b0;
            ovf_out_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load && !full)
                cnt_reg <= cnt_reg + CW'(1);
            else if (cmd.clear)
                cnt_reg <= '0;

            if (cmd.load && full)
                ovf_reg <= 1'b1;
            else if (cmd.clear)
                ovf_reg <= 1'b0;

            // odd-even passes: even pairs then odd pairs, n passes in all
            if (cmd.sort_init)
            begin
                pos_reg  <= '0;
                pass_reg <= '0;
            end
            else if (cmd.sort_step || cmd.pass_skip)
            begin
                if (last_pair)
                begin
                    pos_reg  <= {{(CW-1){1'b0}}, ~pass_reg[0]};
                    pass_reg <= pass_reg + CW'(1);
                end
                else
                    pos_reg <= pos_reg + CW'(2);
            end

            if (cmd.sweep_init)
            begin
                swp_reg  <= '0;
                line_reg <= '0;
            end
            else if (cmd.mark_step)
            begin
                swp_reg      <= swp_reg + CW'(1);
                line_reg     <= line_new;
                prev_bot_reg <= {1'b0, bx_top} + {1'b0, bx_hgt};
            end
            else if (cmd.emit_step)
                swp_reg <= swp_reg + CW'(1);

            if (cmd.emit_step)
            begin
                out_left_reg   <= FB'(bx_left);
                out_top_reg    <= FB'(bx_top);
                out_width_reg  <= FB'(bx_wid);
                out_height_reg <= FB'(bx_hgt);
                out_final_reg  <= (swp_reg + CW'(1) == cnt_reg);
                ovf_out_reg    <= ovf_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_left   = out_left_reg;
    assign out_top    = out_top_reg;
    assign out_width  = out_width_reg;
    assign out_height = out_height_reg;
    assign out_final  = out_final_reg;
    assign overflowed = ovf_out_reg;

    always_comb
    begin
        sts.sort_done  = (pass_reg >= cnt_reg);
        sts.pair_ok    = pair_ok;
        sts.sweep_done = (swp_reg >= cnt_reg);
        sts.out_busy   = out_valid_reg && !out_ready;
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_BOXES)) else $error("count beyond store");
    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sort_read |-> pair_ok) else $error("pair past set");
    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pos_read |-> swp_reg < cnt_reg) else $error("sweep past set");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({out_left, out_top, out_width, out_height, out_final, overflowed}))
        else $error("output beat changed while waiting");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/robs_ctrl.sv =====
// Controller: sequences load, top sort, line marking, left sort, emit.
// Depends on robs_pkg.
`default_nettype none
module robs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                set_end,
    output logic                     in_ready,
    input  wire robs_pkg::robs_sts_t sts,
    output robs_pkg::robs_cmd_t      cmd
);
    typedef enum logic [3:0] {
        S_LOAD, S_TOP_RD, S_TOP_WR, S_MARK_RD, S_MARK_BOX, S_MARK_WR,
        S_LEFT_RD, S_LEFT_WR, S_EMIT_RD, S_EMIT_BOX, S_EMIT_WR
    } state_t;
    state_t state_reg, state_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        in_ready = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && set_end)
                begin
                    cmd.sort_init = 1'b1;
                    state_next = S_TOP_RD;
                end
            end
            S_TOP_RD:
            begin
                if (sts.sort_done)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next = S_MARK_RD;
                end
                else if (!sts.pair_ok)
                    cmd.pass_skip = 1'b1;
                else
                begin
                    cmd.sort_read = 1'b1;
                    state_next = S_TOP_WR;
                end
            end
            S_TOP_WR:
            begin
                cmd.sort_step = 1'b1;
                state_next = S_TOP_RD;
            end
            S_MARK_RD:
            begin
                if (sts.sweep_done)
                begin
                    cmd.sort_init = 1'b1;
                    state_next = S_LEFT_RD;
                end
                else
                begin
                    cmd.pos_read = 1'b1;
                    state_next = S_MARK_BOX;
                end
            end
            S_MARK_BOX:
            begin
                cmd.box_read = 1'b1;
                state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                cmd.mark_step = 1'b1;
                state_next = S_MARK_RD;
            end
            S_LEFT_RD:
            begin
                if (sts.sort_done)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next = S_EMIT_RD;
                end
                else if (!sts.pair_ok)
                    cmd.pass_skip = 1'b1;
                else
                begin
                    cmd.sort_read = 1'b1;
                    state_next = S_LEFT_WR;
                end
            end
            S_LEFT_WR:
            begin
                cmd.sort_step = 1'b1;
                state_next = S_LEFT_RD;
            end
            S_EMIT_RD:
            begin
                if (sts.sweep_done)
                begin
                    cmd.clear = 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.pos_read = 1'b1;
                    state_next = S_EMIT_BOX;
                end
            end
            S_EMIT_BOX:
            begin
                cmd.box_read = 1'b1;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit_step = 1'b1;
                    state_next = S_EMIT_RD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_LOAD) else $error("load outside load state");
    a_close_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && set_end |=> !in_ready) else $error("input open after set end");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> !sts.out_busy) else $error("emit over waiting beat");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.sort_read, cmd.sort_step, cmd.pos_read, cmd.box_read,
                  cmd.mark_step, cmd.emit_step}))
        else $error("overlapping commands");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/reading_order_box_sorter.sv =====
// Top level of the reading-order box sorter: controller plus datapath.
// Depends on robs_pkg, robs_ctrl, robs_datapath.
`default_nettype none
// Boxes load one beat per cycle until the beat with set_end closes the set;
// boxes beyond MAX_BOXES are dropped (the closing one too, though it still
// closes the set) and overflowed is set on every beat of that set. From the
// closing beat on, input is held off until the last beat of the set sits in
// the output register. The block sorts by top edge with one shared
// compare-swap unit over a store with registered reads (odd-even
// transposition, n passes, each compared pair read, then swapped if out of
// order), marks line starts in one sweep that reads each box's sort entry,
// then the box, then writes its line, sorts by line and left edge the same
// way, and emits n beats in reading order, the last with out_final. Receiver
// stalls can hold up the emit sweep.
module reading_order_box_sorter #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [robs_pkg::FIELD_BITS-1:0] box_left,
    input  wire logic [robs_pkg::FIELD_BITS-1:0] box_top,
    input  wire logic [robs_pkg::FIELD_BITS-1:0] box_width,
    input  wire logic [robs_pkg::FIELD_BITS-1:0] box_height,
    input  wire logic                            set_end,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [robs_pkg::FIELD_BITS-1:0]      out_left,
    output logic [robs_pkg::FIELD_BITS-1:0]      out_top,
    output logic [robs_pkg::FIELD_BITS-1:0]      out_width,
    output logic [robs_pkg::FIELD_BITS-1:0]      out_height,
    output logic                                 out_final,
    output logic                                 overflowed
);
    robs_pkg::robs_cmd_t cmd;
    robs_pkg::robs_sts_t sts;

    robs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .set_end(set_end),
        .in_ready(in_ready), .sts(sts), .cmd(cmd)
    );

    robs_datapath #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .box_left(box_left), .box_top(box_top), .box_width(box_width),
        .box_height(box_height),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_left(out_left), .out_top(out_top), .out_width(out_width),
        .out_height(out_height), .out_final(out_final), .overflowed(overflowed)
    );
endmodule
`default_nettype wire
